/* hw/rtl/lrrg_pkg.sv */
package lrrg_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned STEP_W = 5;

    // Generator constants
    localparam logic [WORD_W-1:0] LRRG_MULT  = 32'd279470273;
    localparam logic [WORD_W-1:0] LRRG_PRIME = 32'd4294967291;

    // State loaded at reset: seed 1 with its halves swapped
    localparam logic [WORD_W-1:0] LRRG_RESET_STATE = 32'h0001_0000;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_unit_st;

    // Job entering the modular multiplier
    typedef struct packed {
        logic [WORD_W-1:0] range_limit;
        logic [WORD_W-1:0] state;
    } t_mul_req;

    // Job entering the remainder unit
    typedef struct packed {
        logic [WORD_W-1:0] range_limit;
        logic [WORD_W-1:0] product;
    } t_div_req;

    // Finished result
    typedef struct packed {
        logic [WORD_W-1:0] raw_state;
        logic [WORD_W-1:0] draw_value;
    } t_draw;

endpackage

/* hw/rtl/lehmer_random_range_generator.sv */
// Each item runs through the 32-step bit-serial modular multiplier and then the
//   32-step bit-serial remainder unit, whose done state holds the result. The
//   multiplier takes a new item once it has handed its product on, so it overlaps
//   the remainder unit of the previous item; an output stall holds the handoff.
// Reset (synchronous, active low): both units go idle, no result is pending,
//   and the generator state becomes 0x00010000 (seed 1, halves swapped).
module lehmer_random_range_generator import lrrg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Draw requests
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [WORD_W-1:0] i_s_axis_tdata,   // [31:0] range_limit
    // Results
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [2*WORD_W-1:0] o_m_axis_tdata, // [31:0] draw_value, [63:32] raw_state
    // Seed register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WORD_W-1:0] i_cfg_data        // seed_value
);

    // Generator state. Advanced when the multiplier hands its product on;
    // the multiplier only takes a new item after that handoff, so every
    // item sees the state left by the one before it.
    logic [WORD_W-1:0] r_state, n_state;

    t_mul_req s_mul_req;
    t_div_req s_div_req;
    t_draw    s_draw;
    logic     s_mul_ready;
    logic     s_mul_done;
    logic     s_div_ready;
    logic     s_handoff;

    assign s_mul_req.state       = r_state;
    assign s_mul_req.range_limit = i_s_axis_tdata;
    assign o_s_axis_tready       = s_mul_ready;
    assign o_cfg_ready           = 1'b1;

    // Stage 1: product mod prime, one state bit per cycle
    lrrg_modmul u_modmul (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (s_mul_ready),
        .i_req       (s_mul_req),
        .o_res_valid (s_mul_done),
        .i_res_ready (s_div_ready),
        .o_res       (s_div_req)
    );

    assign s_handoff = s_mul_done & s_div_ready;

    // Stage 2: new state mod range_limit; its done state is the output register
    lrrg_moddiv u_moddiv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_mul_done),
        .o_req_ready (s_div_ready),
        .i_req       (s_div_req),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (s_draw)
    );

    assign o_m_axis_tdata = {s_draw.raw_state, s_draw.draw_value};

    // Seed write reloads the state with its 16-bit halves swapped
    always_comb begin
        priority if (i_cfg_valid) begin
            n_state = {i_cfg_data[WORD_W/2-1:0], i_cfg_data[WORD_W-1:WORD_W/2]};
        end else if (s_handoff) begin
            n_state = s_div_req.product;
        end else begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LRRG_RESET_STATE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    // Multiplier output is always fully reduced
    a_state_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_handoff && !i_cfg_valid) |=> (r_state < LRRG_PRIME))
        else $error("state not reduced below prime after draw");

    // Raw state on the output is below the prime
    a_raw_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (s_draw.raw_state < LRRG_PRIME))
        else $error("raw_state not below prime");

    // An accepted item keeps the multiplier busy
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("multiplier took a second item while busy");
`endif

endmodule

/* hw/rtl/lrrg_modmul.sv */
// Bit-serial (state * LRRG_MULT) mod LRRG_PRIME, Horner order, MSB first.
module lrrg_modmul import lrrg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_mul_req i_req,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_div_req o_res
);

    localparam logic [WORD_W+1:0] P1 = {2'b00, LRRG_PRIME};
    localparam logic [WORD_W+1:0] P2 = {1'b0, LRRG_PRIME, 1'b0};
    localparam logic [WORD_W+1:0] M1 = {2'b00, LRRG_MULT};

    t_unit_st          r_st, n_st;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_opd, n_opd;
    logic [WORD_W-1:0] r_range, n_range;

    logic [WORD_W+1:0] s_sum;
    logic [WORD_W-1:0] s_acc_red;

    // acc < P, so 2*acc + M < 3P: at most two P's come off
    always_comb begin
        s_sum = {1'b0, r_acc, 1'b0} + (r_opd[WORD_W-1] ? M1 : '0);
        priority if (s_sum >= P2) begin
            s_acc_red = WORD_W'(s_sum - P2);
        end else if (s_sum >= P1) begin
            s_acc_red = WORD_W'(s_sum - P1);
        end else begin
            s_acc_red = s_sum[WORD_W-1:0];
        end
    end

    always_comb begin
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_opd   = r_opd;
        n_range = r_range;
        unique case (r_st)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_st    = ST_RUN;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_opd   = i_req.state;
                    n_range = i_req.range_limit;
                end
            end
            ST_RUN: begin
                n_acc = s_acc_red;
                n_opd = {r_opd[WORD_W-2:0], 1'b0};
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(WORD_W - 1)) begin
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
        r_acc   <= n_acc;
        r_opd   <= n_opd;
        r_range <= n_range;
    end

    assign o_req_ready       = (r_st == ST_IDLE);
    assign o_res_valid       = (r_st == ST_DONE);
    assign o_res.product     = r_acc;
    assign o_res.range_limit = r_range;

endmodule

/* hw/rtl/lrrg_moddiv.sv */
// Restoring radix-2 remainder, one dividend bit per cycle.
// A zero divisor never borrows, so the remainder ends as the dividend.
module lrrg_moddiv import lrrg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_div_req i_req,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_draw    o_res
);

    t_unit_st          r_st, n_st;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [WORD_W-1:0] r_dvd, n_dvd;
    logic [WORD_W-1:0] r_raw, n_raw;
    logic [WORD_W-1:0] r_range, n_range;

    logic [WORD_W+1:0] s_diff;
    logic [WORD_W-1:0] s_rem_next;

    // rem < divisor, so {rem, bit} fits in 33 bits, a kept difference in 32; bit 33 flags a borrow
    always_comb begin
        s_diff = {1'b0, r_rem, r_dvd[WORD_W-1]} - {2'b00, r_range};
        if (s_diff[WORD_W+1]) begin
            s_rem_next = {r_rem[WORD_W-2:0], r_dvd[WORD_W-1]};
        end else begin
            s_rem_next = s_diff[WORD_W-1:0];
        end
    end

    always_comb begin
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_raw   = r_raw;
        n_range = r_range;
        unique case (r_st)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_st    = ST_RUN;
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_dvd   = i_req.product;
                    n_raw   = i_req.product;
                    n_range = i_req.range_limit;
                end
            end
            ST_RUN: begin
                n_rem = s_rem_next;
                n_dvd = {r_dvd[WORD_W-2:0], 1'b0};
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(WORD_W - 1)) begin
                    n_st = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_raw   <= n_raw;
        r_range <= n_range;
    end

    assign o_req_ready      = (r_st == ST_IDLE);
    assign o_res_valid      = (r_st == ST_DONE);
    assign o_res.draw_value = r_rem;
    assign o_res.raw_state  = r_raw;

endmodule
